[sv/rtpes_pkg.sv]
// Shared types and constants for the RTP elementary stream packetizer.
// Used by the front, queue, back and top-level modules. No dependencies.
package rtpes_pkg;

  localparam int FrameLengthBits = 24;
  localparam int HeaderBytes     = 12;
  localparam int HdrIdxBits      = $clog2(HeaderBytes + 1);
  localparam int QueueDepth      = 2;
  localparam int QueuePtrBits    = $clog2(QueueDepth);
  localparam int QueueCntBits    = $clog2(QueueDepth + 1);

  localparam logic [15:0] MinPacketSize  = 16'(HeaderBytes + 1);
  localparam logic [15:0] ResetPktCap    = 16'(1400 - HeaderBytes);
  localparam logic [6:0]  ResetPayloadTy = 7'd96;
  localparam logic [7:0]  RtpVersionByte = 8'h80;

  typedef enum logic [1:0] {
    RegMaxPacketSize = 2'd0,
    RegPayloadType   = 2'd1,
    RegStartSequence = 2'd2,
    RegSourceId      = 2'd3
  } cfg_reg_e;

  // One accepted byte after classification by the front.
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic        mark;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        pkt_last;
    logic        frame_end;
  } q_entry_t;

endpackage

[sv/rtp_elementary_stream_packetizer.sv]
// RTP elementary stream packetizer, top level with configuration registers.
// An accepted byte is written into the queue, then loaded into the back's output register.
// Throughput: one output byte per cycle while out_ready_i is high; a byte that
// opens a packet yields 13 output bytes, so the input stalls once the queue fills.
// Reset: asynchronous, active low; clears all counters and the queue and
// loads the register defaults (1400, 96, 0, 0). Depends on rtpes_pkg.
module rtp_elementary_stream_packetizer import rtpes_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       frame_start_i,
  input  logic [FrameLengthBits-1:0] frame_length_i,
  input  logic [31:0]                frame_timestamp_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       packet_first_o,
  output logic                       packet_last_o,
  output logic                       frame_end_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [31:0]                cfg_wdata_i
);

  logic [15:0] pkt_cap_q;
  logic [6:0]  payload_type_q;
  logic [31:0] source_id_q;
  logic [15:0] size_clamped;
  logic        seq_load;
  logic        push, pop, q_full, q_empty;
  q_entry_t    entry, head;

  // The packet size register is kept as the payload capacity per packet.
  assign size_clamped = (cfg_wdata_i[15:0] < MinPacketSize) ? MinPacketSize
                                                            : cfg_wdata_i[15:0];
  assign seq_load = cfg_we_i && (cfg_reg_e'(cfg_index_i) == RegStartSequence);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cap_q      <= ResetPktCap;
      payload_type_q <= ResetPayloadTy;
      source_id_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMaxPacketSize: pkt_cap_q      <= size_clamped - 16'(HeaderBytes);
        RegPayloadType:   payload_type_q <= cfg_wdata_i[6:0];
        RegSourceId:      source_id_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rtpes_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .frame_start_i,
    .frame_length_i,
    .frame_timestamp_i,
    .pkt_cap_i   (pkt_cap_q),
    .seq_load_i  (seq_load),
    .seq_value_i (cfg_wdata_i[15:0]),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (entry)
  );

  rtpes_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  rtpes_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i        (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .payload_type_i (payload_type_q),
    .source_id_i    (source_id_q),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .packet_first_o,
    .packet_last_o,
    .frame_end_o
  );

endmodule

[sv/rtpes_front.sv]
// Front of the packetizer: accepts input bytes, tracks frame and packet
// counts and the sequence number, and classifies each byte. Uses rtpes_pkg.
module rtpes_front import rtpes_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       frame_start_i,
  input  logic [FrameLengthBits-1:0] frame_length_i,
  input  logic [31:0]                frame_timestamp_i,
  input  logic [15:0]                pkt_cap_i,
  input  logic                       seq_load_i,
  input  logic [15:0]                seq_value_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output q_entry_t                   entry_o
);

  logic [FrameLengthBits-1:0] frame_left_q, frame_left_d, frame_eff, frame_new;
  logic [15:0]                pkt_left_q, pkt_left_d, pkt_eff, pkt_new, pay;
  logic [15:0]                seq_q, seq_d;
  logic [31:0]                ts_q, ts_d;
  logic                       accept, hdr, cap_covers;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    frame_eff  = frame_start_i ? frame_length_i : frame_left_q;
    pkt_eff    = frame_start_i ? 16'd0 : pkt_left_q;
    ts_d       = frame_start_i ? frame_timestamp_i : ts_q;
    hdr        = (pkt_eff == 16'd0);
    // The rest of the frame fits into one packet when it does not exceed the cap.
    cap_covers = (frame_eff <= FrameLengthBits'(pkt_cap_i));
    pay        = cap_covers ? frame_eff[15:0] : pkt_cap_i;
    pkt_new    = (hdr ? pay : pkt_eff) - 16'd1;
    frame_new  = frame_eff - FrameLengthBits'(1);

    push_o             = accept && (frame_eff != '0);
    entry_o.data       = data_byte_i;
    entry_o.hdr        = hdr;
    entry_o.mark       = cap_covers;
    entry_o.seq        = seq_q;
    entry_o.ts         = ts_d;
    entry_o.pkt_last   = (pkt_new == 16'd0);
    entry_o.frame_end  = (frame_new == '0);

    frame_left_d = frame_left_q;
    pkt_left_d   = pkt_left_q;
    seq_d        = seq_q;
    if (seq_load_i) begin
      seq_d = seq_value_i;
    end
    if (accept) begin
      if (frame_eff == '0) begin
        frame_left_d = frame_eff;
        pkt_left_d   = pkt_eff;
      end else begin
        frame_left_d = frame_new;
        pkt_left_d   = pkt_new;
        if (hdr) begin
          seq_d = seq_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_left_q <= '0;
      pkt_left_q   <= '0;
      seq_q        <= '0;
      ts_q         <= '0;
    end else begin
      frame_left_q <= frame_left_d;
      pkt_left_q   <= pkt_left_d;
      seq_q        <= seq_d;
      if (accept) begin
        ts_q <= ts_d;
      end
    end
  end

  // A packet never outlasts its frame, so the frame's last byte closes a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.frame_end |-> entry_o.pkt_last)
    else $error("frame end without packet end");

  // Within a packet, the packet count never exceeds the frame count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    FrameLengthBits'(pkt_left_q) <= frame_left_q)
    else $error("packet count exceeds frame count");

endmodule

[sv/rtpes_queue.sv]
// Short queue of classified bytes between the front and the back.
// Register-based, depth from rtpes_pkg.
module rtpes_queue import rtpes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t head_o
);

  q_entry_t                mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wptr_q, rptr_q;
  logic [QueueCntBits-1:0] cnt_q;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntBits'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QueuePtrBits'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntBits'(QueueDepth))
    else $error("queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into a full queue");

endmodule

[sv/rtpes_back.sv]
// Back of the packetizer: expands queued bytes into header and payload bytes
// and holds them in an output register. Uses rtpes_pkg.
module rtpes_back import rtpes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  q_entry_t    head_i,
  output logic        pop_o,
  input  logic [6:0]  payload_type_i,
  input  logic [31:0] source_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_first_o,
  output logic        packet_last_o,
  output logic        frame_end_o
);

  logic [HdrIdxBits-1:0] idx_q;
  logic                  out_valid_q;
  logic [7:0]            byte_q, hdr_byte;
  logic                  first_q, last_q, fend_q;
  logic                  load, hdr_phase;

  assign load      = (!out_valid_q || out_ready_i) && !empty_i;
  assign hdr_phase = head_i.hdr && (idx_q != HdrIdxBits'(HeaderBytes));
  assign pop_o     = load && !hdr_phase;

  always_comb begin
    unique case (idx_q)
      4'd0:    hdr_byte = RtpVersionByte;
      4'd1:    hdr_byte = {head_i.mark, payload_type_i};
      4'd2:    hdr_byte = head_i.seq[15:8];
      4'd3:    hdr_byte = head_i.seq[7:0];
      4'd4:    hdr_byte = head_i.ts[31:24];
      4'd5:    hdr_byte = head_i.ts[23:16];
      4'd6:    hdr_byte = head_i.ts[15:8];
      4'd7:    hdr_byte = head_i.ts[7:0];
      4'd8:    hdr_byte = source_id_i[31:24];
      4'd9:    hdr_byte = source_id_i[23:16];
      4'd10:   hdr_byte = source_id_i[15:8];
      4'd11:   hdr_byte = source_id_i[7:0];
      default: hdr_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= hdr_phase ? idx_q + HdrIdxBits'(1) : '0;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= hdr_phase ? hdr_byte : head_i.data;
      first_q <= hdr_phase && (idx_q == '0);
      last_q  <= !hdr_phase && head_i.pkt_last;
      fend_q  <= !hdr_phase && head_i.frame_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign packet_first_o = first_q;
  assign packet_last_o  = last_q;
  assign frame_end_o    = fend_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= HdrIdxBits'(HeaderBytes))
    else $error("header index out of range");

  // The first header byte of every packet carries the RTP version.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && first_q |-> byte_q == RtpVersionByte && !last_q && !fend_q)
    else $error("bad first header byte");

endmodule
